[rtl/gcd_and_lcm_unit_assert.svh]
// Assertion macros for the gcd / lcm unit checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef GCD_AND_LCM_UNIT_ASSERT_SVH
`define GCD_AND_LCM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GLU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/glu_pkg.sv]
// Shared types, constants and microcode ROM for the gcd / lcm unit.
// No dependencies.
`default_nettype none

package glu_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int GCD_W          = 31;
	localparam int LCM_W          = 62;
	localparam int IN_TDATA_W     = 64;
	localparam int OUT_TDATA_W    = 96;

	// Microprogram steps.
	typedef enum logic [3:0] {
		ST_WAIT,
		ST_CHECK,
		ST_COMMON,
		ST_XEVEN,
		ST_YEVEN,
		ST_SUB,
		ST_GSHIFT,
		ST_DIV,
		ST_MUL,
		ST_EMIT
	} step_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SPECIAL,
		OP_HALF_BOTH,
		OP_HALF_X,
		OP_HALF_Y,
		OP_SUB,
		OP_GSHIFT,
		OP_DIV,
		OP_MUL,
		OP_EMIT
	} op_t;

	// Branch conditions.
	typedef enum logic [3:0] {
		C_ALWAYS,
		C_START,
		C_SPECIAL,
		C_BOTH_EVEN,
		C_X_EVEN,
		C_Y_EVEN,
		C_NEQ,
		C_CNT_NZ,
		C_OUT_FREE
	} cond_t;

	// One control word: when cond holds, op runs and control jumps to
	// target; otherwise control stays (hold) or falls through.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  hold;
	} ucode_t;

	// Status from datapath to sequencer.
	typedef struct packed {
		logic special;
		logic both_even;
		logic x_even;
		logic y_even;
		logic neq;
		logic cnt_nz;
		logic out_free;
	} dp_flags_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		case (step)
			ST_WAIT:   w = '{op: OP_LOAD,      cond: C_START,     target: ST_CHECK,  hold: 1'b1};
			ST_CHECK:  w = '{op: OP_SPECIAL,   cond: C_SPECIAL,   target: ST_EMIT,   hold: 1'b0};
			ST_COMMON: w = '{op: OP_HALF_BOTH, cond: C_BOTH_EVEN, target: ST_COMMON, hold: 1'b0};
			ST_XEVEN:  w = '{op: OP_HALF_X,    cond: C_X_EVEN,    target: ST_XEVEN,  hold: 1'b0};
			ST_YEVEN:  w = '{op: OP_HALF_Y,    cond: C_Y_EVEN,    target: ST_YEVEN,  hold: 1'b0};
			ST_SUB:    w = '{op: OP_SUB,       cond: C_NEQ,       target: ST_XEVEN,  hold: 1'b0};
			ST_GSHIFT: w = '{op: OP_GSHIFT,    cond: C_ALWAYS,    target: ST_DIV,    hold: 1'b0};
			ST_DIV:    w = '{op: OP_DIV,       cond: C_CNT_NZ,    target: ST_DIV,    hold: 1'b0};
			ST_MUL:    w = '{op: OP_MUL,       cond: C_ALWAYS,    target: ST_EMIT,   hold: 1'b0};
			ST_EMIT:   w = '{op: OP_EMIT,      cond: C_OUT_FREE,  target: ST_WAIT,   hold: 1'b1};
			default:   w = '{op: OP_NONE,      cond: C_ALWAYS,    target: ST_WAIT,   hold: 1'b0};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/glu_seq.sv]
// Microcode sequencer: step counter, control ROM lookup, branch logic.
// Depends on glu_pkg.
`default_nettype none

module glu_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire glu_pkg::dp_flags_t flags,
	output      logic              ready,
	output      glu_pkg::op_t      op
);
	import glu_pkg::*;

	step_t  upc_q;
	step_t  upc_d;
	ucode_t word;
	logic   taken;

	always_comb begin
		word = ucode_rom(upc_q);
		case (word.cond)
			C_ALWAYS:    taken = 1'b1;
			C_START:     taken = start;
			C_SPECIAL:   taken = flags.special;
			C_BOTH_EVEN: taken = flags.both_even;
			C_X_EVEN:    taken = flags.x_even;
			C_Y_EVEN:    taken = flags.y_even;
			C_NEQ:       taken = flags.neq;
			C_CNT_NZ:    taken = flags.cnt_nz;
			C_OUT_FREE:  taken = flags.out_free;
			default:     taken = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		if (taken) begin
			upc_d = word.target;
		end else if (word.hold) begin
			upc_d = upc_q;
		end else begin
			upc_d = step_t'(upc_q + 4'd1);
		end
	end

	// outputs
	always_comb begin
		op    = taken ? word.op : OP_NONE;
		ready = (upc_q == ST_WAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_WAIT;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

`default_nettype wire

[rtl/glu_dp.sv]
// Datapath: binary gcd registers, restoring divider, multiplier, output register.
// Depends on glu_pkg; driven by glu_seq.
`default_nettype none

module glu_dp #(
	parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire glu_pkg::op_t                op,
	input  wire logic [glu_pkg::FIELD_W-1:0] a_value,
	input  wire logic [glu_pkg::FIELD_W-1:0] b_value,
	input  wire logic                        out_ready,
	output      glu_pkg::dp_flags_t          flags,
	output      logic                        out_valid,
	output      logic [glu_pkg::GCD_W-1:0]   gcd_result,
	output      logic [glu_pkg::LCM_W-1:0]   lcm_result,
	output      logic                        operand_error
);
	import glu_pkg::*;

	localparam int M  = DATA_WIDTH - 1;
	localparam int CW = $clog2(DATA_WIDTH);
	localparam logic [CW-1:0] CNT_INIT = CW'(M);

	logic [M-1:0]   x_q, y_q, a_q, b_q, g_q, q_q, r_q;
	logic [CW-1:0]  sh_q, cnt_q;
	logic [2*M-1:0] l_q;
	logic           err_q;
	logic           out_vld_q, out_err_q;
	logic [GCD_W-1:0] out_gcd_q;
	logic [LCM_W-1:0] out_lcm_q;

	logic [M:0]      rs, diff;
	logic            ge;
	logic [GCD_W-1:0] g_ext;
	logic [LCM_W-1:0] l_ext;

	always_comb begin
		rs   = {r_q, q_q[M-1]};
		ge   = (rs >= {1'b0, g_q});
		diff = rs - {1'b0, g_q};
		g_ext = '0;
		g_ext[M-1:0] = g_q;
		l_ext = '0;
		l_ext[2*M-1:0] = l_q;
	end

	always_comb begin
		flags.special   = err_q | (x_q == '0) | (y_q == '0);
		flags.both_even = ~x_q[0] & ~y_q[0];
		flags.x_even    = ~x_q[0];
		flags.y_even    = ~y_q[0];
		flags.neq       = (x_q != y_q);
		flags.cnt_nz    = (cnt_q != '0);
		flags.out_free  = ~out_vld_q | out_ready;
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				a_q   <= a_value[M-1:0];
				b_q   <= b_value[M-1:0];
				x_q   <= a_value[M-1:0];
				y_q   <= b_value[M-1:0];
				err_q <= a_value[M] | b_value[M];
				sh_q  <= '0;
			end
			OP_SPECIAL: begin
				g_q <= err_q ? '0 : (x_q | y_q);
				l_q <= '0;
			end
			OP_HALF_BOTH: begin
				x_q  <= x_q >> 1;
				y_q  <= y_q >> 1;
				sh_q <= sh_q + 1'b1;
			end
			OP_HALF_X: x_q <= x_q >> 1;
			OP_HALF_Y: y_q <= y_q >> 1;
			OP_SUB: begin
				if (x_q > y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			OP_GSHIFT: begin
				g_q   <= x_q << sh_q;
				q_q   <= a_q;
				r_q   <= '0;
				cnt_q <= CNT_INIT;
			end
			OP_DIV: begin
				r_q   <= ge ? diff[M-1:0] : rs[M-1:0];
				q_q   <= {q_q[M-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_MUL: l_q <= {{M{1'b0}}, q_q} * {{M{1'b0}}, b_q};
			OP_EMIT: begin
				out_gcd_q <= g_ext;
				out_lcm_q <= l_ext;
				out_err_q <= err_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (op == OP_EMIT) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid     = out_vld_q;
	assign gcd_result    = out_gcd_q;
	assign lcm_result    = out_lcm_q;
	assign operand_error = out_err_q;

endmodule

`default_nettype wire

[rtl/gcd_and_lcm_unit.sv]
// Top level of the gcd / lcm unit: stream ports, sequencer and datapath.
// Depends on glu_pkg, glu_seq, glu_dp.
`default_nettype none

// Takes one transaction holding two signed operands and returns one
// transaction with their greatest common divisor and least common multiple.
// Operands are the low DATA_WIDTH bits of each 32-bit field; a negative
// operand sets operand_error and forces both results to zero. When one
// operand is zero the gcd is the other operand and the lcm is zero. A
// ten-step microprogram runs a binary (shift and subtract) gcd, then a
// restoring divide of the first operand by the gcd, one quotient bit per
// cycle, then one multiply by the second operand. The run time of an item
// is data dependent: it grows with the passes of the shift/subtract loop
// and with each halving, and the divide runs DATA_WIDTH-1 steps. Error and
// zero-operand items skip from the check straight to the output step.
// One item is in work at a time; a result waits in the output register, so
// the next transaction is taken while the previous result is still unread.
module gcd_and_lcm_unit #(
	parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [glu_pkg::IN_TDATA_W-1:0]  s_tdata,  // a_value[31:0], b_value[63:32]
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic [glu_pkg::OUT_TDATA_W-1:0] m_tdata,  // gcd_result[30:0], lcm_result[92:31], zero
	output      logic                            m_tuser   // operand_error
);
	import glu_pkg::*;

	dp_flags_t        flags;
	op_t              op;
	logic [GCD_W-1:0] gcd_result;
	logic [LCM_W-1:0] lcm_result;

	glu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_tvalid),
		.flags  (flags),
		.ready  (s_tready),
		.op     (op)
	);

	glu_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.a_value       (s_tdata[FIELD_W-1:0]),
		.b_value       (s_tdata[2*FIELD_W-1:FIELD_W]),
		.out_ready     (m_tready),
		.flags         (flags),
		.out_valid     (m_tvalid),
		.gcd_result    (gcd_result),
		.lcm_result    (lcm_result),
		.operand_error (m_tuser)
	);

	// pad to whole bytes
	assign m_tdata = {{(OUT_TDATA_W - GCD_W - LCM_W){1'b0}}, lcm_result, gcd_result};

endmodule

`default_nettype wire

[rtl/glu_checker.sv]
// Port-level checker for the gcd / lcm unit, bound to the top level.
// Depends on gcd_and_lcm_unit_assert.svh and gcd_and_lcm_unit.
`default_nettype none

`include "gcd_and_lcm_unit_assert.svh"

module glu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic        m_tuser
);

	`GLU_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser, m_tdata == 96'd0, "error result not zero")

	`GLU_ASSERT_IMP(a_lcm_gcd, m_tvalid && (m_tdata[92:31] != 62'd0), (m_tdata[30:0] != 31'd0) && !m_tuser, "lcm without gcd")

	`GLU_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")

	`GLU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind gcd_and_lcm_unit glu_checker u_glu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
